// ===== sv/owm_pkg.sv =====
// Shared types, constants and register map of the 1-Wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

  // Timer width and the width of one timing register field on the bus.
  localparam int TIME_WIDTH_DEFAULT = 10;
  localparam int CFG_FIELD_W        = 10;

  // Payload widths.
  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int BIT_W  = 3;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 5;
  localparam int NUM_REGS   = 7;

  // Register indexes.
  localparam int REG_RESET_LOW   = 0;
  localparam int REG_PRES_SAMPLE = 1;
  localparam int REG_RESET_RECOV = 2;
  localparam int REG_SHORT_LOW   = 3;
  localparam int REG_LONG_LOW    = 4;
  localparam int REG_READ_DELAY  = 5;
  localparam int REG_SLOT_LEN    = 6;

  // Register values after reset, in microseconds.
  localparam int RESET_LOW_DEF   = 480;
  localparam int PRES_SAMPLE_DEF = 100;
  localparam int RESET_RECOV_DEF = 410;
  localparam int SHORT_LOW_DEF   = 6;
  localparam int LONG_LOW_DEF    = 60;
  localparam int READ_DELAY_DEF  = 9;
  localparam int SLOT_LEN_DEF    = 70;

  // Mode codes of a request.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  // Command class found by the front end.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ,
    CMD_READ_NONE
  } cmd_e;

  // Operation of the back end.
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_RESET,
    OP_WRITE,
    OP_READ
  } op_e;

  // Phase within a reset with presence detect.
  typedef enum logic [1:0] {
    RPH_LOW,
    RPH_WAIT,
    RPH_RECOVER
  } rph_e;

  // Classified request as held in the queue.
  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] read_count;
    logic              line_in;
  } req_t;

  // One result.
  typedef struct packed {
    logic              drive_low;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              last_byte;
    logic              presence_missing;
    logic              done_res;
    logic              busy_res;
  } rsp_t;

  // Queue status.
  typedef struct packed {
    logic                empty;
    logic                full;
    logic [QLEVEL_W-1:0] level;
  } qstat_t;

endpackage

// ===== sv/owm_ifs.sv =====
// Request and result channel interfaces of the 1-Wire bus master.
`timescale 1ns / 1ps

interface owm_req_if import owm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] tx_byte;
  logic [BYTE_W-1:0] read_count;
  logic              line_in;

  modport source (output valid, mode, tx_byte, read_count, line_in, input ready);
  modport sink (input valid, mode, tx_byte, read_count, line_in, output ready);
endinterface

interface owm_rsp_if import owm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_valid;
  logic              last_byte;
  logic              presence_missing;
  logic              done_res;
  logic              busy_res;

  modport source (output valid, drive_low, rx_byte, rx_valid, last_byte, presence_missing,
                  done_res, busy_res, input ready);
  modport sink (input valid, drive_low, rx_byte, rx_valid, last_byte, presence_missing,
                done_res, busy_res, output ready);
endinterface

// ===== sv/owm_front.sv =====
// Front end: takes requests and classifies their command.
`timescale 1ns / 1ps

module owm_front import owm_pkg::*; (
  owm_req_if.sink req_i,
  input  logic    full_i,
  output logic    push_o,
  output req_t    item_o
);

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    item_o.tx_byte    = req_i.tx_byte;
    item_o.read_count = req_i.read_count;
    item_o.line_in    = req_i.line_in;
    unique case (req_i.mode)
      MODE_RESET: item_o.cmd = CMD_RESET;
      MODE_WRITE: item_o.cmd = CMD_WRITE;
      MODE_READ: begin
        // A read of zero bytes finishes on its own tick.
        item_o.cmd = (req_i.read_count == '0) ? CMD_READ_NONE : CMD_READ;
      end
      default: item_o.cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== sv/owm_queue.sv =====
// Short queue of classified requests between the front and the back end.
`timescale 1ns / 1ps

module owm_queue import owm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  req_t   item_i,
  input  logic   pop_i,
  output req_t   item_o,
  output qstat_t stat_o
);

  req_t                entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QLEVEL_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + QLEVEL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - QLEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.empty = (level_q == '0);
  assign stat_o.full  = (level_q == QLEVEL_W'(QUEUE_DEPTH));
  assign stat_o.level = level_q;

endmodule

// ===== sv/owm_back.sv =====
// Back end: slot timing, bit shifting and the result register.
`timescale 1ns / 1ps

module owm_back import owm_pkg::*; #(
  parameter int TimeWidth = TIME_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [NUM_REGS-1:0][TimeWidth-1:0]  timing_i,
  input  req_t                                item_i,
  input  logic                                item_valid_i,
  output logic                                pop_o,
  owm_rsp_if.source                           rsp_o
);

  localparam int EW = TimeWidth + 1;

  function automatic logic [EW-1:0] floor1(logic [TimeWidth-1:0] v);
    floor1 = (v == '0) ? EW'(1) : EW'(v);
  endfunction

  op_e                  op_q, op_d, op_s;
  rph_e                 phase_q, phase_d, ph_s;
  logic [TimeWidth-1:0] count_q, count_d, cnt_s, low;
  logic [BIT_W-1:0]     bit_q, bit_d, bit_s;
  logic [BYTE_W-1:0]    shift_q, shift_d, shift_s;
  logic [BYTE_W-1:0]    left_q, left_d, left_s;
  logic                 presence_q, presence_d;
  logic [EW-1:0]        elapsed, slen, sample_sum, sample_pt;
  logic                 out_valid_q;
  rsp_t                 rsp_q, rsp_d;

  // The read sample point is clamped into the slot.
  always_comb begin
    slen       = floor1(timing_i[REG_SLOT_LEN]);
    sample_sum = EW'(timing_i[REG_SHORT_LOW]) + EW'(timing_i[REG_READ_DELAY]);
    sample_pt  = (sample_sum == '0) ? EW'(1) : sample_sum;
    if (sample_pt > slen) begin
      sample_pt = slen;
    end
  end

  assign pop_o = item_valid_i && (!out_valid_q || rsp_o.ready);

  always_comb begin
    op_s       = op_q;
    ph_s       = phase_q;
    cnt_s      = count_q;
    bit_s      = bit_q;
    shift_s    = shift_q;
    left_s     = left_q;
    presence_d = presence_q;
    rsp_d      = '0;
    low        = '0;

    // A command starts only while no operation runs.
    if (op_q == OP_IDLE && item_i.cmd != CMD_NONE) begin
      cnt_s = '0;
      bit_s = '0;
      ph_s  = RPH_LOW;
      unique case (item_i.cmd)
        CMD_RESET: op_s = OP_RESET;
        CMD_WRITE: begin
          op_s    = OP_WRITE;
          shift_s = item_i.tx_byte;
        end
        CMD_READ: begin
          op_s    = OP_READ;
          left_s  = item_i.read_count;
          shift_s = '0;
        end
        default: rsp_d.done_res = 1'b1;
      endcase
    end

    elapsed = EW'(cnt_s) + EW'(1);
    count_d = cnt_s;

    unique case (op_s) inside
      OP_RESET: begin
        unique case (ph_s)
          RPH_LOW: begin
            rsp_d.drive_low = 1'b1;
            if (elapsed >= floor1(timing_i[REG_RESET_LOW])) begin
              ph_s    = RPH_WAIT;
              elapsed = '0;
            end
          end
          RPH_WAIT: begin
            if (elapsed >= floor1(timing_i[REG_PRES_SAMPLE])) begin
              presence_d = item_i.line_in;
              ph_s       = RPH_RECOVER;
              elapsed    = '0;
            end
          end
          default: begin
            if (elapsed >= floor1(timing_i[REG_RESET_RECOV])) begin
              rsp_d.done_res = 1'b1;
              op_s           = OP_IDLE;
              ph_s           = RPH_LOW;
              elapsed        = '0;
            end
          end
        endcase
        count_d = elapsed[TimeWidth-1:0];
      end
      OP_WRITE, OP_READ: begin
        low = (op_s == OP_WRITE && !shift_s[0]) ? timing_i[REG_LONG_LOW]
                                                : timing_i[REG_SHORT_LOW];
        rsp_d.drive_low = (cnt_s < low);
        if (op_s == OP_READ && elapsed == sample_pt) begin
          shift_s = {item_i.line_in, shift_s[BYTE_W-1:1]};
        end
        if (elapsed >= slen) begin
          elapsed = '0;
          if (op_s == OP_WRITE) begin
            shift_s = shift_s >> 1;
            if (bit_s == '1) begin
              bit_s          = '0;
              rsp_d.done_res = 1'b1;
              op_s           = OP_IDLE;
            end else begin
              bit_s = bit_s + BIT_W'(1);
            end
          end else if (bit_s == '1) begin
            bit_s           = '0;
            rsp_d.rx_valid  = 1'b1;
            rsp_d.rx_byte   = shift_s;
            rsp_d.last_byte = (left_s == BYTE_W'(1));
            left_s          = left_s - BYTE_W'(1);
            shift_s         = '0;
            if (left_s == '0) begin
              rsp_d.done_res = 1'b1;
              op_s           = OP_IDLE;
            end
          end else begin
            bit_s = bit_s + BIT_W'(1);
          end
        end
        count_d = elapsed[TimeWidth-1:0];
      end
      default: ;
    endcase

    op_d    = op_s;
    phase_d = ph_s;
    bit_d   = bit_s;
    shift_d = shift_s;
    left_d  = left_s;
    rsp_d.presence_missing = presence_d;
    rsp_d.busy_res         = (op_s != OP_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_IDLE;
      phase_q    <= RPH_LOW;
      count_q    <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      left_q     <= '0;
      presence_q <= 1'b1;
    end else if (pop_o) begin
      op_q       <= op_d;
      phase_q    <= phase_d;
      count_q    <= count_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      left_q     <= left_d;
      presence_q <= presence_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.drive_low        = rsp_q.drive_low;
  assign rsp_o.rx_byte          = rsp_q.rx_byte;
  assign rsp_o.rx_valid         = rsp_q.rx_valid;
  assign rsp_o.last_byte        = rsp_q.last_byte;
  assign rsp_o.presence_missing = rsp_q.presence_missing;
  assign rsp_o.done_res         = rsp_q.done_res;
  assign rsp_o.busy_res         = rsp_q.busy_res;

endmodule

// ===== sv/onewire_bus_master.sv =====
// 1-Wire bus master top level: timing registers, front end, queue and back end.
// A request waits in the queue until the back end pops it while the output is free; its result is then registered.
// Throughput: one request per cycle; the back end retires one queued tick per cycle unless the output stalls.
// Reset (rst_ni low, asynchronous) idles the master, empties the queue, drops the
// result register and loads the default slot timings; presence reads as missing.
`timescale 1ns / 1ps

module onewire_bus_master import owm_pkg::*; #(
  parameter int TimeWidth = TIME_WIDTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  owm_req_if.sink               req_i,
  owm_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Only the low field bits of a write are kept, and no more than the timer holds.
  localparam int CfgBits = (TimeWidth < CFG_FIELD_W) ? TimeWidth : CFG_FIELD_W;

  logic [NUM_REGS-1:0][TimeWidth-1:0] cfg_q;
  logic [$clog2(NUM_REGS)-1:0]        reg_idx;
  logic                               cfg_wr;

  // Register i sits at byte address 4*i. The port never waits.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (int'(reg_idx) < NUM_REGS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_RESET_LOW]   <= TimeWidth'(RESET_LOW_DEF);
      cfg_q[REG_PRES_SAMPLE] <= TimeWidth'(PRES_SAMPLE_DEF);
      cfg_q[REG_RESET_RECOV] <= TimeWidth'(RESET_RECOV_DEF);
      cfg_q[REG_SHORT_LOW]   <= TimeWidth'(SHORT_LOW_DEF);
      cfg_q[REG_LONG_LOW]    <= TimeWidth'(LONG_LOW_DEF);
      cfg_q[REG_READ_DELAY]  <= TimeWidth'(READ_DELAY_DEF);
      cfg_q[REG_SLOT_LEN]    <= TimeWidth'(SLOT_LEN_DEF);
    end else if (cfg_wr) begin
      cfg_q[reg_idx] <= TimeWidth'(pwdata[CfgBits-1:0]);
    end
  end

  // Reads of an address past the register list return zero.
  always_comb begin
    prdata = '0;
    if (int'(reg_idx) < NUM_REGS) begin
      prdata = APB_DATA_W'(cfg_q[reg_idx]);
    end
  end

  // The front end classifies each request and pushes it whenever the queue
  // has room, so it keeps taking ticks while a result waits at the output.
  logic   push, pop;
  req_t   front_item, head_item;
  qstat_t q_stat;

  owm_front u_front (
    .req_i  (req_i),
    .full_i (q_stat.full),
    .push_o (push),
    .item_o (front_item)
  );

  // Two entries let the front end and the back end stall independently
  // while still passing one request per cycle.
  owm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // The back end runs the reset, write and read slot sequencer one tick per
  // request and registers the result for the output channel.
  owm_back #(
    .TimeWidth (TimeWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timing_i     (cfg_q),
    .item_i       (head_item),
    .item_valid_i (!q_stat.empty),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

`ifndef SYNTH
  // A finished command leaves the master idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.done_res |-> !rsp_o.busy_res)
    else $error("command finished while still busy");

  // The last byte of a read is a delivered byte and ends the command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.last_byte |-> rsp_o.rx_valid && rsp_o.done_res)
    else $error("last byte flagged without a byte or without completion");

  // A push without a pop grows the queue by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> q_stat.level == $past(q_stat.level) + QLEVEL_W'(1))
    else $error("queue level out of step with push");

  // Nothing leaves an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
